// ===== sv/biquad_iir_filter_defines.svh =====
// Assertion macros for the biquad IIR filter block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BIQUAD_IIR_FILTER_DEFINES_SVH
`define BIQUAD_IIR_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside of reset.
`define BIQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define BIQ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define BIQ_ASSERT(label, prop, msg)
`define BIQ_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== sv/biq_pkg.sv =====
// Shared constants, select codes and the sequencer control word for the biquad filter.
// Used by every module of the block; depends on nothing.
package biq_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 24;
    localparam int COEF_INT_BITS    = 4;
    localparam int DELAY_WIDTH      = 48;
    localparam int NUM_COEFS        = 5;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_ADDR_W       = $clog2(NUM_COEFS * 4);

    // Register indexes.
    localparam logic [2:0] REG_B0 = 3'd0;
    localparam logic [2:0] REG_B1 = 3'd1;
    localparam logic [2:0] REG_B2 = 3'd2;
    localparam logic [2:0] REG_A1 = 3'd3;
    localparam logic [2:0] REG_A2 = 3'd4;

    // Multiplier coefficient operand.
    localparam logic [2:0] MA_B0   = 3'd0;
    localparam logic [2:0] MA_B1   = 3'd1;
    localparam logic [2:0] MA_B2   = 3'd2;
    localparam logic [2:0] MA_A1   = 3'd3;
    localparam logic [2:0] MA_A2   = 3'd4;
    localparam logic [2:0] MA_PRE1 = 3'd5;
    localparam logic [2:0] MA_PRE2 = 3'd6;

    // Multiplier sample operand.
    localparam logic [1:0] MB_IN = 2'd0;
    localparam logic [1:0] MB_X  = 2'd1;
    localparam logic [1:0] MB_Y  = 2'd2;

    // Adder operands.
    localparam logic [1:0] AA_ACC  = 2'd0;
    localparam logic [1:0] AA_ACC2 = 2'd1;
    localparam logic [1:0] AA_PROD = 2'd2;

    localparam logic [1:0] AB_ZERO = 2'd0;
    localparam logic [1:0] AB_D1   = 2'd1;
    localparam logic [1:0] AB_D2   = 2'd2;
    localparam logic [1:0] AB_PROD = 2'd3;

    typedef struct packed {
        logic       load;
        logic       op_we;
        logic [2:0] mul_a;
        logic [1:0] mul_b;
        logic [1:0] alu_a;
        logic [1:0] alu_b;
        logic       alu_sub;
        logic       alu_clamp;
        logic       acc_we;
        logic       acc2_we;
        logic       d1_we;
        logic       d2_we;
        logic       y_we;
        logic       done;
    } biq_ctl_t;

endpackage

// ===== sv/biquad_iir_filter.sv =====
// Biquad IIR section, transposed direct form II: a filter word runs through five products
// on the single shared multiplier and a preload word through two; a new word is accepted
// only in idle, once the previous sequence has ended. A result waits in an output register.
// Synchronous active-low reset clears the sequencer, the output valid and both delays,
// and sets the coefficients to pass-through (b0 = 1.0, others zero).
`include "biquad_iir_filter_defines.svh"
module biquad_iir_filter import biq_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_filtered,
    output logic                           m_clipped,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [CFG_ADDR_W-1:0]          paddr,
    input  logic [CFG_DATA_W-1:0]          pwdata,
    output logic [CFG_DATA_W-1:0]          prdata,
    output logic                           pready
);

    localparam int OPA_W  = COEF_WIDTH + 1;
    localparam int PROD_W = OPA_W + SAMPLE_WIDTH;

    biq_ctl_t                        ctl;
    logic                            out_free;
    logic signed [COEF_WIDTH-1:0]    coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic signed [OPA_W-1:0]         op_a_next;
    logic signed [SAMPLE_WIDTH-1:0]  op_b_next;
    logic signed [PROD_W-1:0]        prod;
    logic signed [SAMPLE_WIDTH-1:0]  res_filtered;
    logic                            res_clipped;

    logic                            m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]  m_filtered_reg;
    logic                            m_clipped_reg;

    assign pready   = 1'b1;
    assign out_free = !m_valid_reg || m_ready;

    biq_regs #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .coef_b0 (coef_b0),
        .coef_b1 (coef_b1),
        .coef_b2 (coef_b2),
        .coef_a1 (coef_a1),
        .coef_a2 (coef_a2)
    );

    biq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_kind   (s_kind),
        .s_ready  (s_ready),
        .out_free (out_free),
        .ctl      (ctl)
    );

    biq_mul #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mul (
        .aclk      (aclk),
        .op_we     (ctl.op_we),
        .op_a_next (op_a_next),
        .op_b_next (op_b_next),
        .prod      (prod)
    );

    biq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .s_kind       (s_kind),
        .s_sample     (s_sample),
        .coef_b0      (coef_b0),
        .coef_b1      (coef_b1),
        .coef_b2      (coef_b2),
        .coef_a1      (coef_a1),
        .coef_a2      (coef_a2),
        .prod         (prod),
        .op_a_next    (op_a_next),
        .op_b_next    (op_b_next),
        .res_filtered (res_filtered),
        .res_clipped  (res_clipped)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.done) begin
            m_filtered_reg <= res_filtered;
            m_clipped_reg  <= res_clipped;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;
    assign m_clipped  = m_clipped_reg;

    `BIQ_ASSERT_RST(a_reset_empty, !aresetn |=> (!m_valid && s_ready), "block not empty after reset")

endmodule

// ===== sv/biq_regs.sv =====
// Coefficient register file behind the APB-style configuration port.
// Depends on biq_pkg for register indexes and port widths.
module biq_regs import biq_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic signed [COEF_WIDTH-1:0] coef_b0,
    output logic signed [COEF_WIDTH-1:0] coef_b1,
    output logic signed [COEF_WIDTH-1:0] coef_b2,
    output logic signed [COEF_WIDTH-1:0] coef_a1,
    output logic signed [COEF_WIDTH-1:0] coef_a2
);

    localparam int FRAC = COEF_WIDTH - COEF_INT_BITS;
    localparam logic signed [COEF_WIDTH-1:0] UNITY =
        {{(COEF_WIDTH-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

    logic signed [COEF_WIDTH-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [2:0]                   idx;
    logic                         wr_en;

    assign idx   = paddr[CFG_ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg <= UNITY;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_B0:  b0_reg <= pwdata[COEF_WIDTH-1:0];
                REG_B1:  b1_reg <= pwdata[COEF_WIDTH-1:0];
                REG_B2:  b2_reg <= pwdata[COEF_WIDTH-1:0];
                REG_A1:  a1_reg <= pwdata[COEF_WIDTH-1:0];
                REG_A2:  a2_reg <= pwdata[COEF_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_B0:  prdata = CFG_DATA_W'(b0_reg);
            REG_B1:  prdata = CFG_DATA_W'(b1_reg);
            REG_B2:  prdata = CFG_DATA_W'(b2_reg);
            REG_A1:  prdata = CFG_DATA_W'(a1_reg);
            REG_A2:  prdata = CFG_DATA_W'(a2_reg);
            default: prdata = '0;
        endcase
    end

    assign coef_b0 = b0_reg;
    assign coef_b1 = b1_reg;
    assign coef_b2 = b2_reg;
    assign coef_a1 = a1_reg;
    assign coef_a2 = a2_reg;

endmodule

// ===== sv/biq_mul.sv =====
// Shared signed multiplier: registered operands and a registered product.
// Depends on biq_pkg for default widths.
module biq_mul import biq_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     op_we,
    input  logic signed [COEF_WIDTH:0]               op_a_next,
    input  logic signed [SAMPLE_WIDTH-1:0]           op_b_next,
    output logic signed [COEF_WIDTH+SAMPLE_WIDTH:0]  prod
);

    localparam int PROD_W = COEF_WIDTH + 1 + SAMPLE_WIDTH;

    logic signed [COEF_WIDTH:0]       op_a_reg;
    logic signed [SAMPLE_WIDTH-1:0]   op_b_reg;
    logic signed [PROD_W-1:0]         prod_reg;

    always_ff @(posedge aclk) begin
        if (op_we) begin
            op_a_reg <= op_a_next;
            op_b_reg <= op_b_next;
        end
        // The product follows the operands in the next cycle and holds while they hold.
        prod_reg <= PROD_W'(op_a_reg) * PROD_W'(op_b_reg);
    end

    assign prod = prod_reg;

endmodule

// ===== sv/biq_datapath.sv =====
// Datapath: operand selection, adder with 48-bit saturation, output rounding,
// accumulators and the two delay registers. Depends on biq_pkg.
module biq_datapath import biq_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  biq_ctl_t                                 ctl,
    input  logic                                     s_kind,
    input  logic signed [SAMPLE_WIDTH-1:0]           s_sample,
    input  logic signed [COEF_WIDTH-1:0]             coef_b0,
    input  logic signed [COEF_WIDTH-1:0]             coef_b1,
    input  logic signed [COEF_WIDTH-1:0]             coef_b2,
    input  logic signed [COEF_WIDTH-1:0]             coef_a1,
    input  logic signed [COEF_WIDTH-1:0]             coef_a2,
    input  logic signed [COEF_WIDTH+SAMPLE_WIDTH:0]  prod,
    output logic signed [COEF_WIDTH:0]               op_a_next,
    output logic signed [SAMPLE_WIDTH-1:0]           op_b_next,
    output logic signed [SAMPLE_WIDTH-1:0]           res_filtered,
    output logic                                     res_clipped
);

    localparam int FRAC   = COEF_WIDTH - COEF_INT_BITS;
    localparam int OPA_W  = COEF_WIDTH + 1;
    localparam int PROD_W = OPA_W + SAMPLE_WIDTH;
    localparam int ACC_W  = ((PROD_W > DELAY_WIDTH) ? PROD_W : DELAY_WIDTH) + 2;

    localparam logic signed [DELAY_WIDTH-1:0] D48_MAX = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
    localparam logic signed [DELAY_WIDTH-1:0] D48_MIN = {1'b1, {(DELAY_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] D_MAX = ACC_W'(D48_MAX);
    localparam logic signed [ACC_W-1:0] D_MIN = ACC_W'(D48_MIN);

    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] Y_MAX_W = ACC_W'(Y_MAX);
    localparam logic signed [ACC_W-1:0] Y_MIN_W = ACC_W'(Y_MIN);

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [OPA_W-1:0] ONE_F =
        {{(OPA_W-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

    logic                           kind_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg, y_next;
    logic                           clip_reg, clip_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [DELAY_WIDTH-1:0]  acc2_reg;
    logic signed [DELAY_WIDTH-1:0]  d1_reg, d2_reg;

    logic signed [ACC_W-1:0]        alu_a_v, alu_b_v, alu_raw;
    logic signed [DELAY_WIDTH-1:0]  alu_sat;
    logic signed [ACC_W-1:0]        rnd_sum, rnd_shift;

    // Multiplier operand selection.
    always_comb begin
        unique case (ctl.mul_a)
            MA_B0:   op_a_next = OPA_W'(coef_b0);
            MA_B1:   op_a_next = OPA_W'(coef_b1);
            MA_B2:   op_a_next = OPA_W'(coef_b2);
            MA_A1:   op_a_next = OPA_W'(coef_a1);
            MA_A2:   op_a_next = OPA_W'(coef_a2);
            MA_PRE1: op_a_next = ONE_F - OPA_W'(coef_b0);
            MA_PRE2: op_a_next = OPA_W'(coef_b2) - OPA_W'(coef_a2);
            default: op_a_next = '0;
        endcase
        unique case (ctl.mul_b)
            MB_IN:   op_b_next = s_sample;
            MB_X:    op_b_next = x_reg;
            MB_Y:    op_b_next = y_reg;
            default: op_b_next = '0;
        endcase
    end

    // Shared adder; d1, d2 and acc2 take its saturated sum, acc when asked.
    always_comb begin
        unique case (ctl.alu_a)
            AA_ACC:  alu_a_v = acc_reg;
            AA_ACC2: alu_a_v = ACC_W'(acc2_reg);
            AA_PROD: alu_a_v = ACC_W'(prod);
            default: alu_a_v = '0;
        endcase
        unique case (ctl.alu_b)
            AB_ZERO: alu_b_v = '0;
            AB_D1:   alu_b_v = ACC_W'(d1_reg);
            AB_D2:   alu_b_v = ACC_W'(d2_reg);
            AB_PROD: alu_b_v = ACC_W'(prod);
            default: alu_b_v = '0;
        endcase
        alu_raw = ctl.alu_sub ? (alu_a_v - alu_b_v) : (alu_a_v + alu_b_v);
        priority if (alu_raw > D_MAX) begin
            alu_sat = D48_MAX;
        end else if (alu_raw < D_MIN) begin
            alu_sat = D48_MIN;
        end else begin
            alu_sat = alu_raw[DELAY_WIDTH-1:0];
        end
        acc_next = ctl.alu_clamp ? ACC_W'(alu_sat) : alu_raw;
    end

    // Round half up, then saturate to the sample range.
    always_comb begin
        rnd_sum   = acc_reg + RND_HALF;
        rnd_shift = rnd_sum >>> FRAC;
        priority if (rnd_shift > Y_MAX_W) begin
            y_next    = Y_MAX;
            clip_next = 1'b1;
        end else if (rnd_shift < Y_MIN_W) begin
            y_next    = Y_MIN;
            clip_next = 1'b1;
        end else begin
            y_next    = rnd_shift[SAMPLE_WIDTH-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            kind_reg <= s_kind;
            x_reg    <= s_sample;
        end
        if (ctl.y_we) begin
            y_reg    <= y_next;
            clip_reg <= clip_next;
        end
        if (ctl.acc_we) begin
            acc_reg <= acc_next;
        end
        if (ctl.acc2_we) begin
            acc2_reg <= alu_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else begin
            if (ctl.d1_we) begin
                d1_reg <= alu_sat;
            end
            if (ctl.d2_we) begin
                d2_reg <= alu_sat;
            end
        end
    end

    // A preload echoes its sample and never reports a clip.
    assign res_filtered = kind_reg ? x_reg : y_reg;
    assign res_clipped  = !kind_reg && clip_reg;

endmodule

// ===== sv/biq_ctrl.sv =====
// Sequencer that steps the shared multiplier and adder through one word.
// Depends on biq_pkg and the assertion macros in biquad_iir_filter_defines.svh.
`include "biquad_iir_filter_defines.svh"
module biq_ctrl import biq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_kind,
    output logic     s_ready,
    input  logic     out_free,
    output biq_ctl_t ctl
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_F1   = 4'd1;
    localparam logic [3:0] ST_F2   = 4'd2;
    localparam logic [3:0] ST_F3   = 4'd3;
    localparam logic [3:0] ST_F4   = 4'd4;
    localparam logic [3:0] ST_F5   = 4'd5;
    localparam logic [3:0] ST_F6   = 4'd6;
    localparam logic [3:0] ST_F7   = 4'd7;
    localparam logic [3:0] ST_F8   = 4'd8;
    localparam logic [3:0] ST_P1   = 4'd9;
    localparam logic [3:0] ST_P2   = 4'd10;
    localparam logic [3:0] ST_P3   = 4'd11;

    logic [3:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Operands pass through the operand registers and then the product register before a product is used.
    always_comb begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    ctl.op_we  = 1'b1;
                    ctl.mul_a  = s_kind ? MA_PRE1 : MA_B0;
                    ctl.mul_b  = MB_IN;
                    state_next = s_kind ? ST_P1 : ST_F1;
                end
            end
            ST_F1: begin
                ctl.op_we  = 1'b1;
                ctl.mul_a  = MA_B1;
                ctl.mul_b  = MB_X;
                state_next = ST_F2;
            end
            ST_F2: begin
                // Sum for the output: b0*x + d1, kept at full width.
                ctl.alu_a  = AA_PROD;
                ctl.alu_b  = AB_D1;
                ctl.acc_we = 1'b1;
                ctl.op_we  = 1'b1;
                ctl.mul_a  = MA_B2;
                ctl.mul_b  = MB_X;
                state_next = ST_F3;
            end
            ST_F3: begin
                ctl.y_we      = 1'b1;
                ctl.alu_a     = AA_PROD;
                ctl.alu_b     = AB_ZERO;
                ctl.alu_clamp = 1'b1;
                ctl.acc_we    = 1'b1;
                state_next    = ST_F4;
            end
            ST_F4: begin
                ctl.alu_a   = AA_PROD;
                ctl.alu_b   = AB_ZERO;
                ctl.acc2_we = 1'b1;
                ctl.op_we   = 1'b1;
                ctl.mul_a   = MA_A1;
                ctl.mul_b   = MB_Y;
                state_next  = ST_F5;
            end
            ST_F5: begin
                ctl.op_we  = 1'b1;
                ctl.mul_a  = MA_A2;
                ctl.mul_b  = MB_Y;
                state_next = ST_F6;
            end
            ST_F6: begin
                ctl.alu_a     = AA_ACC;
                ctl.alu_b     = AB_PROD;
                ctl.alu_sub   = 1'b1;
                ctl.alu_clamp = 1'b1;
                ctl.acc_we    = 1'b1;
                state_next    = ST_F7;
            end
            ST_F7: begin
                // The old d2 is still in place here.
                ctl.alu_a  = AA_ACC;
                ctl.alu_b  = AB_D2;
                ctl.d1_we  = 1'b1;
                state_next = ST_F8;
            end
            ST_F8: begin
                ctl.alu_a   = AA_ACC2;
                ctl.alu_b   = AB_PROD;
                ctl.alu_sub = 1'b1;
                if (out_free) begin
                    ctl.d2_we  = 1'b1;
                    ctl.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_P1: begin
                ctl.op_we  = 1'b1;
                ctl.mul_a  = MA_PRE2;
                ctl.mul_b  = MB_X;
                state_next = ST_P2;
            end
            ST_P2: begin
                ctl.alu_a  = AA_PROD;
                ctl.alu_b  = AB_ZERO;
                ctl.d1_we  = 1'b1;
                state_next = ST_P3;
            end
            ST_P3: begin
                ctl.alu_a = AA_PROD;
                ctl.alu_b = AB_ZERO;
                if (out_free) begin
                    ctl.d2_we  = 1'b1;
                    ctl.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `BIQ_ASSERT(a_accept_starts, (state_reg == ST_IDLE && s_valid) |=> (state_reg == ST_F1 || state_reg == ST_P1), "accepted word did not start a sequence")
    `BIQ_ASSERT(a_done_needs_room, ctl.done |-> out_free, "result issued while output register is full")
    `BIQ_ASSERT(a_last_step_holds, (state_reg == ST_F8 && !out_free) |=> (state_reg == ST_F8), "last filter step left while output was stalled")

endmodule
